[hw/rtl/assert_macros.svh]
// assertion macros used by histogram_contrast_stretch_rgb
// no dependencies; take in with `include before use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/hcs_pkg.sv]
// types and helper functions for the histogram contrast stretch block
// no dependencies; used by hcs_lane and histogram_contrast_stretch_rgb
`timescale 1ns / 1ps

package hcs_pkg;

   // register indexes of the csr port
   localparam logic CSR_FIXED_GAIN = 1'b0;
   localparam logic CSR_USE_SUB    = 1'b1;

   // control from the sequencer to each colour lane
   typedef struct packed {
      logic [7:0] addr;
      logic       use_pix;
      logic       we;
      logic       clr;
      logic       load;
      logic       start;
      logic       step;
   } lane_ctrl_type;

   // optional subtrahend: clamp(a - b + 128, 0, 255)
   function automatic logic [7:0] prep(input logic [7:0] a, input logic [7:0] b,
                                       input logic en);
      logic signed [9:0] v;
      v = $signed({2'b00, a}) - $signed({2'b00, b}) + 10'sd128;
      if (!en)
         return a;
      else if (v < 0)
         return 8'd0;
      else if (v > 10'sd255)
         return 8'd255;
      else
         return v[7:0];
   endfunction

endpackage

[hw/rtl/hcs_lane.sv]
// one colour lane: histogram memory and the stretch arithmetic for one channel
// depends on hcs_pkg
`timescale 1ns / 1ps

module hcs_lane #(
   parameter int COUNT_BITS = 22
) (
   input  logic                  clock,
   input  hcs_pkg::lane_ctrl_type ctrl,
   input  logic [7:0]            pix_in,
   input  logic [15:0]           gain,
   input  logic [7:0]            spread,
   output logic [COUNT_BITS-1:0] rd_data,
   output logic [7:0]            result
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [COUNT_BITS-1:0] mem [256];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic [7:0]            pix_ff;
   logic [7:0]            rd_addr;
   logic [7:0]            wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   // divider state
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [7:0]  q_ff, q_in;
   logic        div_on_ff, div_on_in;

   // start-of-scale terms
   logic signed [9:0]  d;
   logic [16:0]        m257;
   logic signed [18:0] num_a;
   logic signed [26:0] prod;
   logic signed [28:0] num_f;

   // histogram memory, registered read
   assign rd_addr = ctrl.use_pix ? pix_ff : ctrl.addr;
   assign wr_addr = ctrl.clr ? ctrl.addr : pix_ff;
   assign wr_data = ctrl.clr ? '0 : ((rdata_ff == CNT_MAX) ? CNT_MAX : rdata_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rd_data = rdata_ff;

   // scale terms
   always_comb begin
      d     = $signed({2'b00, pix_ff}) - 10'sd128;
      m257  = {1'b0, spread, 8'b0} + 17'(spread);
      num_a = (19'(d) <<< 8) + $signed({2'b00, m257});
      prod  = d * $signed({1'b0, gain});
      num_f = (29'(prod) <<< 1) + 29'sd65792;
   end

   // scale setup and restoring divide, one quotient bit a step
   always_comb begin
      rem_in    = rem_ff;
      den_in    = den_ff;
      q_in      = q_ff;
      div_on_in = div_on_ff;
      if (ctrl.start) begin
         div_on_in = 1'b0;
         rem_in    = num_a[16:0];
         den_in    = {spread, 8'b0};
         q_in      = 8'd0;
         if (gain != 16'd0) begin
            if (num_f < 0)
               q_in = 8'd0;
            else if (num_f[28:9] > 20'd255)
               q_in = 8'd255;
            else
               q_in = num_f[16:9];
         end else if (spread == 8'd0) begin
            q_in = pix_ff;
         end else if (num_a < 0) begin
            q_in = 8'd0;
         end else if (num_a >= $signed({2'b00, spread, 9'b0})) begin
            q_in = 8'd255;
         end else begin
            div_on_in = 1'b1;
         end
      end else if (ctrl.step && div_on_ff) begin
         if (rem_ff >= {1'b0, den_ff}) begin
            rem_in = rem_ff - {1'b0, den_ff};
            q_in   = {q_ff[6:0], 1'b1};
         end else begin
            q_in = {q_ff[6:0], 1'b0};
         end
         den_in = den_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pix_ff <= pix_in;
      end
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      q_ff      <= q_in;
      div_on_ff <= div_on_in;
   end

   assign result = q_ff;

endmodule

[hw/rtl/histogram_contrast_stretch_rgb.sv]
// top level of the rgb percentile contrast stretch
// depends on hcs_pkg, hcs_lane and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Pixels arrive as an analyze pass (mode 0) and then an apply pass (mode 1)
// of the same frame; one item is worked at a time. An analyze item is a
// read-modify-write of the three histogram memories; the first analyze item
// of a new frame first runs a clearing pass over the memories. An apply item
// runs the scale setup and the 8-step quotient loop; the first apply item of a
// frame first walks the histograms bin by bin, from the low end and then from
// the high end. After reset a clearing pass runs before the first item is
// taken; csr writes are taken at any time.
module histogram_contrast_stretch_rgb #(
   parameter int COUNT_BITS = 22
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic [7:0]  req_sub_red,
   input  logic [7:0]  req_sub_green,
   input  logic [7:0]  req_sub_blue,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int SW = COUNT_BITS + 7;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_INC_RD, S_INC_WR, S_WALK_RD, S_WALK_ACC,
      S_SCALE, S_DIV, S_FIN
   } state_type;

   state_type state_ff;
   logic [7:0]            idx_ff;
   logic [7:0]            left_ff;
   logic                  walk_right_ff;
   logic                  pend_ff;
   logic                  phase_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic [7:0]            spread_ff;
   logic [SW-1:0]         sum_ff [3];
   logic                  rsp_valid_ff;
   logic [7:0]            out_ff [3];
   logic [15:0]           gain_ff;
   logic                  use_sub_ff;

   hcs_pkg::lane_ctrl_type ctrl;
   logic [7:0]             pix [3];
   logic [COUNT_BITS-1:0]  rd_data [3];
   logic [7:0]             result [3];
   logic                   req_xfer;
   logic                   over;
   logic [7:0]             right_b;
   logic [7:0]             span_a;
   logic [7:0]             span_b;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // working pixel after the optional subtrahend
   assign pix[0] = hcs_pkg::prep(req_in_red, req_sub_red, use_sub_ff);
   assign pix[1] = hcs_pkg::prep(req_in_green, req_sub_green, use_sub_ff);
   assign pix[2] = hcs_pkg::prep(req_in_blue, req_sub_blue, use_sub_ff);

   // lane control from the sequencer state
   always_comb begin
      ctrl         = '0;
      ctrl.addr    = idx_ff;
      ctrl.load    = req_xfer;
      case (state_ff)
         S_CLEAR: begin
            ctrl.we  = 1'b1;
            ctrl.clr = 1'b1;
         end
         S_INC_RD: ctrl.use_pix = 1'b1;
         S_INC_WR: ctrl.we = 1'b1;
         S_SCALE:  ctrl.start = 1'b1;
         S_DIV:    ctrl.step = 1'b1;
         default:  ctrl.use_pix = 1'b0;
      endcase
   end

   // border test: sum > floor(total/20) is the same as 20*sum > total
   always_comb begin
      over = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (({sum_ff[i], 4'b0} + {2'b00, sum_ff[i], 2'b0})
             > (SW + 4)'(total_ff)) begin
            over = 1'b1;
         end
      end
      right_b = over ? idx_ff + 8'd1 : 8'd128;
      span_a  = 8'd128 - left_ff;
      span_b  = right_b - 8'd128;
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= '0;
         use_sub_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hcs_pkg::CSR_FIXED_GAIN: gain_ff    <= csr_data;
            hcs_pkg::CSR_USE_SUB:    use_sub_ff <= csr_data[0];
            default:                 gain_ff    <= gain_ff;
         endcase
      end
   end

   // result valid: set when a result enters the output register, cleared on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FIN && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         phase_ff      <= 1'b0;
         total_ff      <= '0;
         spread_ff     <= '0;
         walk_right_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 8'd1;
               if (idx_ff == 8'd255) begin
                  state_ff <= pend_ff ? S_INC_RD : S_IDLE;
                  pend_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (req_xfer) begin
                  idx_ff <= '0;
                  if (!req_mode) begin
                     if (phase_ff) begin
                        pend_ff  <= 1'b1;
                        phase_ff <= 1'b0;
                        total_ff <= '0;
                        state_ff <= S_CLEAR;
                     end else begin
                        state_ff <= S_INC_RD;
                     end
                  end else if (!phase_ff) begin
                     walk_right_ff <= 1'b0;
                     for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
                     state_ff <= S_WALK_RD;
                  end else begin
                     state_ff <= S_SCALE;
                  end
               end
            end
            S_INC_RD: state_ff <= S_INC_WR;
            S_INC_WR: begin
               if (total_ff != CNT_MAX) total_ff <= total_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            S_WALK_RD: begin
               if (!walk_right_ff) begin
                  if (over || idx_ff == 8'd128) begin
                     left_ff       <= over ? idx_ff - 8'd1 : 8'd128;
                     walk_right_ff <= 1'b1;
                     idx_ff        <= 8'd255;
                     for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
                  end else begin
                     state_ff <= S_WALK_ACC;
                  end
               end else if (over || idx_ff == 8'd128) begin
                  spread_ff <= (span_a > span_b) ? span_a : span_b;
                  phase_ff  <= 1'b1;
                  state_ff  <= S_SCALE;
               end else begin
                  state_ff <= S_WALK_ACC;
               end
            end
            S_WALK_ACC: begin
               for (int i = 0; i < 3; i++) sum_ff[i] <= sum_ff[i] + SW'(rd_data[i]);
               idx_ff   <= walk_right_ff ? idx_ff - 8'd1 : idx_ff + 8'd1;
               state_ff <= S_WALK_RD;
            end
            S_SCALE: begin
               idx_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               idx_ff <= idx_ff + 8'd1;
               if (idx_ff == 8'd7) state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  for (int i = 0; i < 3; i++) out_ff[i] <= result[i];
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // colour lanes
   for (genvar i = 0; i < 3; i++) begin : g_lane
      hcs_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .pix_in  (pix[i]),
         .gain    (gain_ff),
         .spread  (spread_ff),
         .rd_data (rd_data[i]),
         .result  (result[i])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

   // checks
   `ASSERT_IMPL(a_spread_range, clock, reset, 1'b1, spread_ff <= 8'd128)
   `ASSERT_IMPL(a_clear_analyzing, clock, reset, state_ff == S_CLEAR, !phase_ff)
   `ASSERT_IMPL(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FIN)
   `ASSERT_NEXT(a_walk_sets_phase, clock, reset,
                state_ff == S_WALK_RD && walk_right_ff && (over || idx_ff == 8'd128),
                phase_ff)

endmodule

[sim/histogram_contrast_stretch_rgb_tb.sv]
// testbench for the rgb percentile contrast stretch: directed and random frames
// depends on hcs_pkg and histogram_contrast_stretch_rgb
`timescale 1ns / 1ps

module histogram_contrast_stretch_rgb_tb;

   localparam int CNT_W = 22;
   localparam int CNT_TOP = (1 << CNT_W) - 1;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [7:0]  req_in_red = '0, req_in_green = '0, req_in_blue = '0;
   logic [7:0]  req_sub_red = '0, req_sub_green = '0, req_sub_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red, rsp_out_green, rsp_out_blue;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = hcs_pkg::CSR_FIXED_GAIN;
   logic [15:0] csr_data = '0;

   // predictor state
   int          hist_r [256];
   int          hist_g [256];
   int          hist_b [256];
   int          pix_count;
   int          spread_m;
   bit          applying;
   logic [15:0] gain_q88;
   bit          sub_on;

   pix_type     stretched_q[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          hold_rsp = 1'b0;
   int          hold_len = 0;

   always #6 clock = ~clock;

   histogram_contrast_stretch_rgb u_dut (.*);

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int subtract_chan(int a, int b);
      int v;
      v = a;
      if (sub_on) begin
         v = a - b + 128;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
      end
      return v;
   endfunction

   function automatic logic [7:0] stretch_chan(int p);
      longint d, num, q;
      d = p - 128;
      if (gain_q88 != 0) begin
         num = d * 2 * longint'(gain_q88) + 65792;
         if (num < 0) return 8'd0;
         q = num / 512;
      end else if (spread_m == 0) begin
         return p[7:0];
      end else begin
         num = d * 256 + 257 * longint'(spread_m);
         if (num < 0) return 8'd0;
         q = num / (2 * spread_m);
      end
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // border walk to the 5 percent points
   task automatic find_spread();
      longint lim, sr, sg, sb;
      int lo, hi;
      lim = pix_count / 20;
      sr = 0; sg = 0; sb = 0;
      for (lo = 0; lo < 128; lo++) begin
         sr += hist_r[lo]; sg += hist_g[lo]; sb += hist_b[lo];
         if (sr > lim || sg > lim || sb > lim) break;
      end
      sr = 0; sg = 0; sb = 0;
      for (hi = 255; hi > 128; hi--) begin
         sr += hist_r[hi]; sg += hist_g[hi]; sb += hist_b[hi];
         if (sr > lim || sg > lim || sb > lim) break;
      end
      spread_m = (128 - lo > hi - 128) ? 128 - lo : hi - 128;
   endtask

   task automatic predict_pixel(bit mode, pix_type px, pix_type sb);
      int r, g, b;
      pix_type res;
      r = subtract_chan(px.red, sb.red);
      g = subtract_chan(px.green, sb.green);
      b = subtract_chan(px.blue, sb.blue);
      if (!mode) begin
         if (applying) begin
            for (int i = 0; i < 256; i++) begin
               hist_r[i] = 0; hist_g[i] = 0; hist_b[i] = 0;
            end
            pix_count = 0;
            applying = 1'b0;
         end
         if (hist_r[r] < CNT_TOP) hist_r[r]++;
         if (hist_g[g] < CNT_TOP) hist_g[g]++;
         if (hist_b[b] < CNT_TOP) hist_b[b]++;
         if (pix_count < CNT_TOP) pix_count++;
      end else begin
         if (!applying) begin
            find_spread();
            applying = 1'b1;
         end
         res.red = stretch_chan(r);
         res.green = stretch_chan(g);
         res.blue = stretch_chan(b);
         stretched_q.push_back(res);
      end
   endtask

   task automatic random_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
          ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      repeat (n) @(negedge clock);
   endtask

   // one pixel transfer on the input channel
   task automatic send_pixel(bit mode, pix_type px, pix_type sb, bit gaps = 1);
      if (gaps) random_gap();
      req_valid = 1'b1;
      req_mode <= mode;
      req_in_red <= px.red; req_in_green <= px.green; req_in_blue <= px.blue;
      req_sub_red <= sb.red; req_sub_green <= sb.green; req_sub_blue <= sb.blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(mode, px, sb);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (stretched_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      csr_valid = 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == hcs_pkg::CSR_FIXED_GAIN) gain_q88 = val; else sub_on = val[0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic pix_type rand_pix(int lo = 0, int hi = 255);
      pix_type p;
      p.red = 8'($urandom_range(lo, hi));
      p.green = 8'($urandom_range(lo, hi));
      p.blue = 8'($urandom_range(lo, hi));
      return p;
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      pix_type exp_px;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stretched_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h %h %h",
                                           rsp_out_red, rsp_out_green, rsp_out_blue);
         end else begin
            exp_px = stretched_q.pop_front();
            if (exp_px != {rsp_out_red, rsp_out_green, rsp_out_blue}) begin
               mismatches++;
               if (mismatches <= 10) $display("result mismatch: expected %h actual %h",
                                              exp_px, {rsp_out_red, rsp_out_green, rsp_out_blue});
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_len > 0) begin
         hold_len <= hold_len - 1;
         rsp_stall <= 1'b1;
      end else if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
         hold_len <= $urandom_range(5, 30);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // one frame: analyze pass then the same pixels as apply pass
   task automatic run_frame(int n, int lo, int hi, bit gaps = 1);
      pix_type px[$], sb[$];
      for (int i = 0; i < n; i++) begin
         px.push_back(rand_pix(lo, hi));
         sb.push_back(rand_pix());
      end
      foreach (px[i]) send_pixel(1'b0, px[i], sb[i], gaps);
      foreach (px[i]) send_pixel(1'b1, px[i], sb[i], gaps);
   endtask

   task automatic test_directed();
      pix_type zero_px, full_px;
      zero_px = '0;
      full_px = '1;
      // apply with empty histograms gives unity gain
      send_pixel(1'b1, full_px, zero_px);
      send_pixel(1'b1, 24'h805a11, zero_px);
      // flat frame gives zero spread
      repeat (4) send_pixel(1'b0, 24'h808080, zero_px);
      send_pixel(1'b1, 24'h808080, zero_px);
      send_pixel(1'b1, full_px, zero_px);
      send_pixel(1'b1, zero_px, zero_px);
      // extremes frame
      send_pixel(1'b0, zero_px, zero_px);
      send_pixel(1'b0, full_px, zero_px);
      send_pixel(1'b0, 24'h7f7f7f, zero_px);
      send_pixel(1'b1, zero_px, zero_px);
      send_pixel(1'b1, full_px, zero_px);
      send_pixel(1'b1, 24'h7f8081, zero_px);
      wait_drained();
      // subtrahend with clamping both ways, fixed gain at extremes
      write_reg(hcs_pkg::CSR_USE_SUB, 16'd1);
      write_reg(hcs_pkg::CSR_FIXED_GAIN, 16'hffff);
      send_pixel(1'b0, zero_px, full_px);
      send_pixel(1'b1, zero_px, full_px);
      send_pixel(1'b1, full_px, zero_px);
      send_pixel(1'b1, 24'h102030, 24'h0a1424);
      wait_drained();
      write_reg(hcs_pkg::CSR_FIXED_GAIN, 16'h0001);
      send_pixel(1'b1, full_px, zero_px);
      send_pixel(1'b1, zero_px, full_px);
      wait_drained();
      write_reg(hcs_pkg::CSR_FIXED_GAIN, 16'd0);
      write_reg(hcs_pkg::CSR_USE_SUB, 16'd0);
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 1200) begin
         int n, lo, hi;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
         lo = $urandom_range(0, 200);
         hi = $urandom_range(lo, 255);
         if ($urandom_range(0, 3) == 0) begin
            lo = 0; hi = 255;
         end
         if ($urandom_range(0, 7) == 0) begin
            send_pixel(1'($urandom_range(0, 1)), rand_pix(), rand_pix());
            sent += 1;
         end else begin
            run_frame(n, lo, hi);
            sent += 2 * n;
         end
         if ($urandom_range(0, 5) == 0) begin
            wait_drained();
            case ($urandom_range(0, 3))
               0: write_reg(hcs_pkg::CSR_FIXED_GAIN, 16'd0);
               1: write_reg(hcs_pkg::CSR_FIXED_GAIN, 16'($urandom_range(0, 65535)));
               2: write_reg(hcs_pkg::CSR_FIXED_GAIN, 16'($urandom_range(64, 1024)));
               default: write_reg(hcs_pkg::CSR_USE_SUB, 16'($urandom_range(0, 1)));
            endcase
         end
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      write_reg(hcs_pkg::CSR_FIXED_GAIN, 16'd0);
      write_reg(hcs_pkg::CSR_USE_SUB, 16'd0);
      // receiver holds off while the sender keeps offering
      hold_rsp = 1'b1;
      fork
         run_frame(16, 0, 255, 1'b0);
         begin
            repeat (800) @(negedge clock);
            hold_rsp = 1'b0;
         end
      join
      // sender pauses until everything is back
      wait_drained();
      run_frame(8, 30, 220);
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         hist_r[i] = 0; hist_g[i] = 0; hist_b[i] = 0;
      end
      pix_count = 0;
      spread_m = 0;
      applying = 1'b0;
      gain_q88 = '0;
      sub_on = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      if (mismatches == 0 && stretched_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
